// File: rtl/core/rdq_pkg.sv
package rdq_pkg;

    // default sizing
    localparam int DEPTH_DEFAULT      = 256;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    // fixed port widths
    localparam int KIND_W      = 3;
    localparam int ITEM_PORT_W = 32;
    localparam int POS_W       = 8;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int ACCESS_W    = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // store access carried out by the back end
    localparam logic [ACCESS_W-1:0] ACC_NONE  = 2'd0;
    localparam logic [ACCESS_W-1:0] ACC_READ  = 2'd1;
    localparam logic [ACCESS_W-1:0] ACC_WRITE = 2'd2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ACCESS_W-1:0] access;
        logic [STATUS_W-1:0] status;
    } cmd_ctrl_t;

endpackage

// File: rtl/core/rdq_front.sv
module rdq_front #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEFAULT,
    localparam int SLOT_W    = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [rdq_pkg::KIND_W-1:0]      kind,
    input  logic [rdq_pkg::ITEM_PORT_W-1:0] item_in,
    input  logic [rdq_pkg::POS_W-1:0]       position,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output rdq_pkg::cmd_ctrl_t             cmd_ctrl,
    output logic [SLOT_W-1:0]              cmd_slot,
    output logic [ITEM_WIDTH-1:0]          cmd_item,
    output logic [CNT_W-1:0]               cmd_count
);
    import rdq_pkg::*;

    localparam int SUM_W = SLOT_W + 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [SLOT_W-1:0] front_reg;
    logic [SLOT_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              in_range;

    // sum below twice the depth folds back with one compare and subtract
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return t[SLOT_W-1:0];
    endfunction

    assign req_ready = cmd_ready;
    assign cmd_valid = req_valid;
    assign accept    = req_valid && cmd_ready;
    assign cmd_item  = ITEM_WIDTH'(item_in);
    assign cmd_count = count_next;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign in_range = (CMP_W'(position) < CMP_W'(count_reg));

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        cmd_ctrl.access = ACC_NONE;
        cmd_ctrl.status = ST_OK;
        cmd_slot        = front_reg;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    cmd_ctrl.status = ST_FULL;
                end
                else
                begin
                    front_next      = (front_reg == '0) ? SLOT_W'(DEPTH - 1)
                                                        : (front_reg - 1'b1);
                    cmd_slot        = front_next;
                    cmd_ctrl.access = ACC_WRITE;
                    count_next      = count_reg + 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (is_full)
                begin
                    cmd_ctrl.status = ST_FULL;
                end
                else
                begin
                    cmd_slot        = wrap_slot(SUM_W'(front_reg) + SUM_W'(count_reg));
                    cmd_ctrl.access = ACC_WRITE;
                    count_next      = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (is_empty)
                begin
                    cmd_ctrl.status = ST_EMPTY;
                end
                else
                begin
                    cmd_slot        = front_reg;
                    cmd_ctrl.access = ACC_READ;
                    front_next      = wrap_slot(SUM_W'(front_reg) + SUM_W'(1));
                    count_next      = count_reg - 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (is_empty)
                begin
                    cmd_ctrl.status = ST_EMPTY;
                end
                else
                begin
                    cmd_slot        = wrap_slot(SUM_W'(front_reg) + SUM_W'(count_reg)
                                                - SUM_W'(1));
                    cmd_ctrl.access = ACC_READ;
                    count_next      = count_reg - 1'b1;
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                if (!in_range)
                begin
                    cmd_ctrl.status = ST_RANGE;
                end
                else
                begin
                    cmd_slot        = wrap_slot(SUM_W'(front_reg) + SUM_W'(position));
                    cmd_ctrl.access = (kind == KIND_READ) ? ACC_READ : ACC_WRITE;
                end
            end
            default:
            begin
                // count request and the unused code: report only
                cmd_ctrl.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/rdq_queue.sv
module rdq_queue #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import rdq_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/rdq_back.sv
module rdq_back #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEFAULT,
    localparam int SLOT_W    = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  rdq_pkg::cmd_ctrl_t              cmd_ctrl,
    input  logic [SLOT_W-1:0]               cmd_slot,
    input  logic [ITEM_WIDTH-1:0]           cmd_item,
    input  logic [CNT_W-1:0]                cmd_count,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [rdq_pkg::ITEM_PORT_W-1:0] item_out,
    output logic [rdq_pkg::COUNT_W-1:0]     item_count,
    output logic [rdq_pkg::STATUS_W-1:0]    status
);
    import rdq_pkg::*;

    logic [ITEM_WIDTH-1:0] ring_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  is_read_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  issue;

    // a new command goes out once the response register is free or draining
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign issue     = cmd_valid && cmd_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (issue)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            if (cmd_ctrl.access == ACC_WRITE)
            begin
                ring_mem[cmd_slot] <= cmd_item;
            end
            rd_data_reg <= ring_mem[cmd_slot];
            is_read_reg <= (cmd_ctrl.access == ACC_READ);
            count_reg   <= cmd_count;
            status_reg  <= cmd_ctrl.status;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign item_out   = is_read_reg ? ITEM_PORT_W'(rd_data_reg) : '0;
    assign item_count = COUNT_W'(count_reg);
    assign status     = status_reg;

endmodule

// File: rtl/core/ring_deque_with_indexed_access_unit.sv
// Ring deque with indexed access. Items live in one ring store of DEPTH entries addressed by
// a front pointer and an item count. Each request (kind: push front, push back, pop front,
// pop back, read at position, write at position, count) gives exactly one response with the
// popped or read item (zero otherwise), the count after the step and a status (ok, full on
// push, empty on pop, index out of range); a refused request leaves the deque unchanged.
// Timing: an accepted request passes through the command queue and then the response register
// of the back end before its response is presented. One request per cycle is sustained while
// the response side keeps taking responses. That rate is set by the single port of the ring
// store, which serves one command per cycle: it reads the addressed entry and, on a write,
// also writes it. The front end updates pointer and count as it accepts a request; a two-entry
// command queue sits between front and back, so together with the response register up to
// three accepted requests are held before a stalled response side drops request ready. The
// store needs no clearing after reset: only entries already written can be read.
module ring_deque_with_indexed_access_unit #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [rdq_pkg::KIND_W-1:0]      kind,
    input  logic [rdq_pkg::ITEM_PORT_W-1:0] item_in,
    input  logic [rdq_pkg::POS_W-1:0]       position,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [rdq_pkg::ITEM_PORT_W-1:0] item_out,
    output logic [rdq_pkg::COUNT_W-1:0]     item_count,
    output logic [rdq_pkg::STATUS_W-1:0]    status
);
    import rdq_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = $bits(cmd_ctrl_t) + SLOT_W + ITEM_WIDTH + CNT_W;

    // front side of the command queue
    logic                  f_valid;
    logic                  f_ready;
    cmd_ctrl_t             f_ctrl;
    logic [SLOT_W-1:0]     f_slot;
    logic [ITEM_WIDTH-1:0] f_item;
    logic [CNT_W-1:0]      f_count;

    // back side of the command queue
    logic                  b_valid;
    logic                  b_ready;
    cmd_ctrl_t             b_ctrl;
    logic [SLOT_W-1:0]     b_slot;
    logic [ITEM_WIDTH-1:0] b_item;
    logic [CNT_W-1:0]      b_count;
    logic [CMD_W-1:0]      b_data;

    // classify the request, check it against the count and move the pointers
    rdq_front #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .kind       (kind),
        .item_in    (item_in),
        .position   (position),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd_ctrl   (f_ctrl),
        .cmd_slot   (f_slot),
        .cmd_item   (f_item),
        .cmd_count  (f_count)
    );

    // commands in request order, so store accesses keep their order
    rdq_queue #(
        .WIDTH      (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctrl, f_slot, f_item, f_count}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_ctrl, b_slot, b_item, b_count} = b_data;

    // ring store access and response register
    rdq_back #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd_ctrl   (b_ctrl),
        .cmd_slot   (b_slot),
        .cmd_item   (b_item),
        .cmd_count  (b_count),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .item_out   (item_out),
        .item_count (item_count),
        .status     (status)
    );

endmodule

// File: tb/ring_deque_with_indexed_access_unit_test.sv
module ring_deque_with_indexed_access_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    // kind 7 has no meaning of its own and is served like a count request
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    localparam int RING_DEPTH    = DEPTH_DEFAULT;
    localparam int REQUEST_GOAL  = 1800;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int REPORT_LIMIT  = 10;

    // what one response should carry
    typedef struct {
        logic [ITEM_PORT_W-1:0] item;
        logic [COUNT_W-1:0]     count;
        logic [STATUS_W-1:0]    status;
    } deque_response_t;

    // mirror of the deque plus the responses still owed by the block
    class deque_scoreboard;
        logic [ITEM_PORT_W-1:0] ring [RING_DEPTH];
        logic [POS_W-1:0]       front;
        int                     held;
        deque_response_t        awaited [$];
        int                     mismatches;
        int                     responses;
        int                     requests;
        int                     peak;
        int                     status_seen [4];

        function void note_request(logic [KIND_W-1:0] k, logic [ITEM_PORT_W-1:0] it,
                                   logic [POS_W-1:0] pos);
            deque_response_t  r;
            logic [POS_W-1:0] slot;
            r.item   = '0;
            r.status = ST_OK;
            case (k)
                KIND_PUSH_FRONT:
                    if (held >= RING_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        front       = front - 1'b1;
                        ring[front] = it;
                        held++;
                    end
                KIND_PUSH_BACK:
                    if (held >= RING_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slot       = front + POS_W'(held);
                        ring[slot] = it;
                        held++;
                    end
                KIND_POP_FRONT:
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.item = ring[front];
                        front  = front + 1'b1;
                        held--;
                    end
                KIND_POP_BACK:
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        slot   = front + POS_W'(held - 1);
                        r.item = ring[slot];
                        held--;
                    end
                KIND_READ:
                    if (int'(pos) >= held)
                        r.status = ST_RANGE;
                    else
                    begin
                        slot   = front + pos;
                        r.item = ring[slot];
                    end
                KIND_WRITE:
                    if (int'(pos) >= held)
                        r.status = ST_RANGE;
                    else
                    begin
                        slot       = front + pos;
                        ring[slot] = it;
                    end
                default:
                    ;
            endcase
            r.count = COUNT_W'(held);
            awaited.push_back(r);
            requests++;
            status_seen[r.status]++;
            if (held > peak)
                peak = held;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_response(logic [ITEM_PORT_W-1:0] it, logic [COUNT_W-1:0] cnt,
                                     logic [STATUS_W-1:0] st);
            deque_response_t r;
            responses++;
            if (awaited.size() == 0)
            begin
                report($sformatf("response with no request outstanding: item %h count %0d status %0d",
                                 it, cnt, st));
                return;
            end
            r = awaited.pop_front();
            if (it !== r.item || cnt !== r.count || st !== r.status)
                report($sformatf("response %0d: item %h/%h count %0d/%0d status %0d/%0d (exp/got)",
                                 responses, r.item, it, r.count, cnt, r.status, st));
        endfunction
    endclass

    // request phases of the random part
    typedef enum logic [1:0] {GROWING, SHRINKING, ACCESSING, NOISE} phase_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [KIND_W-1:0]      kind = KIND_COUNT;
    logic [ITEM_PORT_W-1:0] item_in = '0;
    logic [POS_W-1:0]       position = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [ITEM_PORT_W-1:0] item_out;
    logic [COUNT_W-1:0]     item_count;
    logic [STATUS_W-1:0]    status;

    deque_scoreboard sb = new;

    // no random idling on either side while set
    bit steady = 1'b0;
    // raised by the request side, taken and cleared by the response side
    bit hold_off_pending = 1'b0;
    int cycle_count = 0;

    ring_deque_with_indexed_access_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .kind       (kind),
        .item_in    (item_in),
        .position   (position),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .item_out   (item_out),
        .item_count (item_count),
        .status     (status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog: a correct run ends far below this
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles, %0d responses outstanding",
                         cycle_count, sb.awaited.size());
                $display("ring_deque_with_indexed_access_unit_test failed");
                $finish;
            end
        end
    end

    // response side: random stalls, one long hold-off on request, checks at the rising edge
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ready <= steady || ($urandom_range(99) >= 6);
            @(posedge clk);
            if (rsp_valid && rsp_ready && rst_n)
                sb.check_response(item_out, item_count, status);
        end
    end

    // offer one request, with an occasional one-cycle gap ahead of it, and wait for the
    // handshake; valid stays high from one request to the next when there is no gap
    task automatic offer(input logic [KIND_W-1:0] k, input logic [ITEM_PORT_W-1:0] it,
                         input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 6)
            gap = 1;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        kind      <= k;
        item_in   <= it;
        position  <= pos;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(k, it, pos);
    endtask

    // item handles lean towards the extremes now and then
    function automatic logic [ITEM_PORT_W-1:0] pick_item();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        return $urandom();
    endfunction

    // positions mostly inside the held range, the rest anywhere
    function automatic logic [POS_W-1:0] pick_position();
        if (sb.held > 0 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(sb.held - 1));
        return POS_W'($urandom_range(255));
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(phase_mode_t mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            GROWING:
                if (r < 70)
                    return r[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                else if (r < 80)
                    return r[0] ? KIND_POP_BACK : KIND_POP_FRONT;
                else if (r < 88)
                    return KIND_READ;
                else if (r < 96)
                    return KIND_WRITE;
                else
                    return r[0] ? KIND_SPARE : KIND_COUNT;
            SHRINKING:
                if (r < 70)
                    return r[0] ? KIND_POP_BACK : KIND_POP_FRONT;
                else if (r < 80)
                    return r[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                else if (r < 88)
                    return KIND_READ;
                else if (r < 96)
                    return KIND_WRITE;
                else
                    return r[0] ? KIND_SPARE : KIND_COUNT;
            ACCESSING:
                if (r < 40)
                    return KIND_READ;
                else if (r < 80)
                    return KIND_WRITE;
                else if (r < 90)
                    return KIND_KIND_MIX(r);
                else
                    return r[0] ? KIND_SPARE : KIND_COUNT;
            default:
                return KIND_W'($urandom_range(7));
        endcase
    endfunction

    // any of the four push and pop kinds
    function automatic logic [KIND_W-1:0] KIND_KIND_MIX(int r);
        case (r % 4)
            0: return KIND_PUSH_FRONT;
            1: return KIND_PUSH_BACK;
            2: return KIND_POP_FRONT;
            default: return KIND_POP_BACK;
        endcase
    endfunction

    task automatic offer_random(phase_mode_t mode);
        logic [KIND_W-1:0] k;
        k = pick_kind(mode);
        offer(k, pick_item(), pick_position());
    endtask

    initial
    begin
        phase_mode_t mode;
        int          phase_len;
        bit          second_hold_done;
        second_hold_done = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: refusals on an empty deque, spare kind, extreme handles,
        // reads and writes at and past the ends, then back to empty
        offer(KIND_POP_FRONT,  '0,           8'd0);
        offer(KIND_POP_BACK,   '1,           8'd255);
        offer(KIND_READ,       '0,           8'd0);
        offer(KIND_WRITE,      32'h1234_5678, 8'd0);
        offer(KIND_COUNT,      '1,           8'd255);
        offer(KIND_SPARE,      '1,           8'd255);
        offer(KIND_PUSH_FRONT, '0,           8'd0);
        offer(KIND_PUSH_BACK,  '1,           8'd255);
        offer(KIND_PUSH_FRONT, 32'hA5A5_A5A5, 8'd0);
        offer(KIND_READ,       '0,           8'd0);
        offer(KIND_READ,       '0,           8'd2);
        offer(KIND_READ,       '0,           8'd3);
        offer(KIND_READ,       '1,           8'd255);
        offer(KIND_WRITE,      32'h5A5A_5A5A, 8'd1);
        offer(KIND_WRITE,      32'h0F0F_0F0F, 8'd3);
        offer(KIND_READ,       '0,           8'd1);
        offer(KIND_POP_BACK,   '0,           8'd0);
        offer(KIND_POP_FRONT,  '0,           8'd0);
        offer(KIND_POP_FRONT,  '0,           8'd0);
        offer(KIND_POP_BACK,   '0,           8'd0);
        offer(KIND_PUSH_BACK,  32'h0000_0001, 8'd0);
        offer(KIND_POP_BACK,   '0,           8'd0);

        // response side holds off while requests keep coming, so the block fills and stalls
        hold_off_pending = 1'b1;

        // fill to the brim from both ends, then push against a full deque
        while (sb.held < RING_DEPTH)
            offer($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_item(), 8'd0);
        offer(KIND_PUSH_FRONT, pick_item(), 8'd0);
        offer(KIND_PUSH_BACK,  pick_item(), 8'd0);
        offer(KIND_READ,       '0,          8'd255);
        offer(KIND_WRITE,      '1,          8'd255);
        offer(KIND_READ,       '0,          8'd255);
        offer(KIND_READ,       '0,          8'd0);

        // random phases, mostly well-formed traffic with a share of noise
        while (sb.requests < REQUEST_GOAL)
        begin
            steady = (sb.requests >= 700 && sb.requests < 1000);
            if (!second_hold_done && sb.requests >= 1300)
            begin
                hold_off_pending = 1'b1;
                second_hold_done = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2: mode = GROWING;
                3, 4, 5: mode = SHRINKING;
                6, 7, 8: mode = ACCESSING;
                default: mode = NOISE;
            endcase
            phase_len = $urandom_range(20, 120);
            repeat (phase_len)
                offer_random(mode);
        end
        steady = 1'b0;

        // drain to empty and pop past it
        while (sb.held > 0)
            offer($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, '0, 8'd0);
        offer(KIND_POP_FRONT, '0, 8'd0);
        offer(KIND_POP_BACK,  '0, 8'd0);
        offer(KIND_COUNT,     '0, 8'd0);

        @(negedge clk);
        req_valid <= 1'b0;

        // let the outstanding responses come home, then watch for strays
        while (sb.awaited.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.awaited.size() > 0)
            sb.report($sformatf("%0d responses never arrived", sb.awaited.size()));

        $display("%0d requests, %0d responses, %0d mismatches; peak fill %0d of %0d",
                 sb.requests, sb.responses, sb.mismatches, sb.peak, RING_DEPTH);
        $display("outcomes: ok %0d, full %0d, empty %0d, out of range %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
        if (sb.mismatches == 0)
            $display("ring_deque_with_indexed_access_unit_test passed");
        else
            $display("ring_deque_with_indexed_access_unit_test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rdq_pkg.sv
rtl/core/rdq_front.sv
rtl/core/rdq_queue.sv
rtl/core/rdq_back.sv
rtl/core/ring_deque_with_indexed_access_unit.sv
tb/ring_deque_with_indexed_access_unit_test.sv
